// File: sv/imh_pkg.sv
// ----------------------------------------------------------------------------
// imh_pkg - shared types and codes of the indexed min-heap
// Commands, status codes, datapath micro-ops and the control/status bundles
// passed between the controller and the datapath.
// ----------------------------------------------------------------------------
package imh_pkg;

  localparam logic [1:0] CMD_LOAD  = 2'd0;
  localparam logic [1:0] CMD_POP   = 2'd1;
  localparam logic [1:0] CMD_DEC   = 2'd2;
  localparam logic [1:0] CMD_QUERY = 2'd3;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_EMPTY    = 3'd1;
  localparam logic [2:0] ST_NOCHANGE = 3'd2;
  localparam logic [2:0] ST_RANGE    = 3'd3;
  localparam logic [2:0] ST_PHASE    = 3'd4;

  typedef logic [4:0] op_t;

  localparam op_t OP_NONE       = 5'd0;
  localparam op_t OP_ACCEPT     = 5'd1;
  localparam op_t OP_LOAD       = 5'd2;
  localparam op_t OP_BUILD_INIT = 5'd3;
  localparam op_t OP_BUILD_RD   = 5'd4;
  localparam op_t OP_CUR_LD     = 5'd5;
  localparam op_t OP_SD_RDL     = 5'd6;
  localparam op_t OP_SD_RDR     = 5'd7;
  localparam op_t OP_SD_STEP    = 5'd8;
  localparam op_t OP_POP_RDL    = 5'd9;
  localparam op_t OP_POS_RD     = 5'd10;
  localparam op_t OP_SLOT_RD    = 5'd11;
  localparam op_t OP_CHECK      = 5'd12;
  localparam op_t OP_SU_RD      = 5'd13;
  localparam op_t OP_SU_STEP    = 5'd14;
  localparam op_t OP_PLACE      = 5'd15;
  localparam op_t OP_EMIT       = 5'd16;

  typedef struct packed {
    op_t op;
  } imh_cmd_t;

  typedef struct packed {
    logic       err;
    logic [1:0] cmd;
    logic       last_load;
    logic       m_zero;
    logic       sd_stop;
    logic       do_sift;
    logic       at_top;
    logic       su_stop;
    logic       out_busy;
  } imh_stat_t;

endpackage

// File: sv/imh_ifs.sv
// ----------------------------------------------------------------------------
// imh_ifs - channel interfaces of the indexed min-heap
// Request, response and configuration channels, each valid/ready.
// ----------------------------------------------------------------------------
interface imh_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [9:0]  item;
  logic [31:0] priority_req;
  modport source (output valid, command, item, priority_req, input ready);
  modport sink   (input valid, command, item, priority_req, output ready);
endinterface

interface imh_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [9:0]  result_item;
  logic [31:0] result_priority;
  logic        present;
  logic [9:0]  min_item;
  logic [31:0] min_priority;
  logic [10:0] heap_size;
  modport source (output valid, status, result_item, result_priority, present,
                  min_item, min_priority, heap_size, input ready);
  modport sink   (input valid, status, result_item, result_priority, present,
                  min_item, min_priority, heap_size, output ready);
endinterface

interface imh_cfg_if;
  logic        valid;
  logic        ready;
  logic [10:0] item_count;
  modport source (output valid, item_count, input ready);
  modport sink   (input valid, item_count, output ready);
endinterface

// File: sv/imh_ctrl.sv
// ----------------------------------------------------------------------------
// imh_ctrl - sequencer of the indexed min-heap
// Steps the datapath through load, build, pop, decrease and query.
// ----------------------------------------------------------------------------
module imh_ctrl
  import imh_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_ready,
  input  imh_stat_t stat,
  output imh_cmd_t  cmd
);

  localparam logic [4:0] S_IDLE       = 5'd0;
  localparam logic [4:0] S_DISPATCH   = 5'd1;
  localparam logic [4:0] S_LOAD       = 5'd2;
  localparam logic [4:0] S_BUILD_INIT = 5'd3;
  localparam logic [4:0] S_BUILD_NEXT = 5'd4;
  localparam logic [4:0] S_CUR        = 5'd5;
  localparam logic [4:0] S_SD_L       = 5'd6;
  localparam logic [4:0] S_SD_R       = 5'd7;
  localparam logic [4:0] S_SD_STEP    = 5'd8;
  localparam logic [4:0] S_POP_L      = 5'd9;
  localparam logic [4:0] S_SLOT       = 5'd10;
  localparam logic [4:0] S_CHECK      = 5'd11;
  localparam logic [4:0] S_SU_RD      = 5'd12;
  localparam logic [4:0] S_SU_STEP    = 5'd13;
  localparam logic [4:0] S_ROOT       = 5'd14;
  localparam logic [4:0] S_EMIT       = 5'd15;

  logic [4:0] state, state_next;
  logic       in_build, in_build_next;

  assign req_ready = (state == S_IDLE);

  always_comb begin
    state_next    = state;
    in_build_next = in_build;
    cmd.op        = OP_NONE;
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.op     = OP_ACCEPT;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (stat.err) begin
          state_next = S_ROOT;
        end else begin
          unique case (stat.cmd)
            CMD_LOAD: state_next = S_LOAD;
            CMD_POP:  state_next = S_POP_L;   // root read issued by default address
            default: begin
              cmd.op     = OP_POS_RD;
              state_next = S_SLOT;
            end
          endcase
        end
      end
      S_LOAD: begin
        cmd.op     = OP_LOAD;
        state_next = stat.last_load ? S_BUILD_INIT : S_ROOT;
      end
      S_BUILD_INIT: begin
        cmd.op        = OP_BUILD_INIT;
        in_build_next = 1'b1;
        state_next    = S_BUILD_NEXT;
      end
      S_BUILD_NEXT: begin
        if (stat.m_zero) begin
          in_build_next = 1'b0;
          state_next    = S_ROOT;
        end else begin
          cmd.op     = OP_BUILD_RD;
          state_next = S_CUR;
        end
      end
      S_CUR: begin
        cmd.op     = OP_CUR_LD;
        state_next = S_SD_L;
      end
      S_SD_L: begin
        cmd.op     = OP_SD_RDL;
        state_next = S_SD_R;
      end
      S_SD_R: begin
        cmd.op     = OP_SD_RDR;
        state_next = S_SD_STEP;
      end
      S_SD_STEP: begin
        cmd.op = OP_SD_STEP;
        if (stat.sd_stop) begin
          state_next = in_build ? S_BUILD_NEXT : S_ROOT;
        end else begin
          state_next = S_SD_L;
        end
      end
      S_POP_L: begin
        cmd.op     = OP_POP_RDL;
        state_next = S_CUR;
      end
      S_SLOT: begin
        cmd.op     = OP_SLOT_RD;
        state_next = S_CHECK;
      end
      S_CHECK: begin
        cmd.op     = OP_CHECK;
        state_next = stat.do_sift ? S_SU_RD : S_ROOT;
      end
      S_SU_RD: begin
        if (stat.at_top) begin
          cmd.op     = OP_PLACE;
          state_next = S_ROOT;
        end else begin
          cmd.op     = OP_SU_RD;
          state_next = S_SU_STEP;
        end
      end
      S_SU_STEP: begin
        cmd.op     = OP_SU_STEP;
        state_next = stat.su_stop ? S_ROOT : S_SU_RD;
      end
      S_ROOT: begin
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (!stat.out_busy) begin
          cmd.op     = OP_EMIT;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      in_build <= 1'b0;
    end else begin
      state    <= state_next;
      in_build <= in_build_next;
    end
  end

endmodule

// File: sv/imh_dp.sv
// ----------------------------------------------------------------------------
// imh_dp - datapath of the indexed min-heap
// Key, slot-to-item and item-to-slot memories, the sift registers and the
// output register. Sifts move a hole and write the moving entry at the end.
// ----------------------------------------------------------------------------
module imh_dp
  import imh_pkg::*;
#(
  parameter int CAPACITY = 1024,
  parameter int KEY_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  imh_cmd_t    cmd,
  output imh_stat_t   stat,
  input  logic        cfg_valid,
  input  logic [10:0] cfg_item_count,
  input  logic [1:0]  req_command,
  input  logic [9:0]  req_item,
  input  logic [31:0] req_priority,
  output logic        rsp_valid,
  input  logic        rsp_ready,
  output logic [2:0]  rsp_status,
  output logic [9:0]  rsp_result_item,
  output logic [31:0] rsp_result_priority,
  output logic        rsp_present,
  output logic [9:0]  rsp_min_item,
  output logic [31:0] rsp_min_priority,
  output logic [10:0] rsp_heap_size
);

  localparam int SB = $clog2(CAPACITY);
  localparam int CB = $clog2(CAPACITY + 1);
  localparam int EB = SB + 2;

  logic [KEY_BITS-1:0] key_mem  [CAPACITY];
  logic [SB-1:0]       slot_mem [CAPACITY];
  logic [SB-1:0]       pos_mem  [CAPACITY];

  logic [KEY_BITS-1:0] rd_key;
  logic [SB-1:0]       rd_slot, rd_pos;

  // control state
  logic [10:0] item_count;
  logic        built;
  logic [CB-1:0] live, load_idx, m;
  logic        err;

  // payload
  logic [1:0]          cmd_q;
  logic [9:0]          item_q;
  logic [KEY_BITS-1:0] key_q;
  logic [2:0]          status_q;
  logic [9:0]          r_item;
  logic [KEY_BITS-1:0] r_key;
  logic                r_present;
  logic [SB-1:0]       a, cur_item, litem, s_q;
  logic [CB-1:0]       n;
  logic [KEY_BITS-1:0] cur_key, lkey;

  // combinational
  logic [CB-1:0]       eff, m_dec, live_dec;
  logic [CB:0]         li_inc;
  logic [EB-1:0]       l_idx, r_idx;
  logic [SB-1:0]       p_idx;
  logic                l_ok, r_ok, pick_l, pick_r, sd_stop, su_stop;
  logic [KEY_BITS-1:0] best_key, child_key;
  logic [SB-1:0]       child_item, child_idx;
  logic                here, lower;
  logic [2:0]          acc_status;

  logic                wr_en, pos_we;
  logic [SB-1:0]       wa, ws, pa, pd, ra;
  logic [KEY_BITS-1:0] wk;

  always_comb begin
    if (item_count == 11'd0) begin
      eff = CB'(1);
    end else if (32'(item_count) > 32'(CAPACITY)) begin
      eff = CB'(CAPACITY);
    end else begin
      eff = CB'(item_count);
    end
  end

  assign li_inc   = {1'b0, load_idx} + (CB + 1)'(1);
  assign m_dec    = m - CB'(1);
  assign live_dec = live - CB'(1);

  assign l_idx   = EB'({a, 1'b1});
  assign r_idx   = l_idx + EB'(1);
  assign p_idx   = (a - SB'(1)) >> 1;
  assign l_ok    = l_idx < EB'(n);
  assign r_ok    = r_idx < EB'(n);
  assign pick_l  = l_ok && (lkey < cur_key);
  assign best_key = pick_l ? lkey : cur_key;
  assign pick_r  = r_ok && (rd_key < best_key);
  assign sd_stop = !pick_l && !pick_r;
  assign child_key  = pick_r ? rd_key : lkey;
  assign child_item = pick_r ? rd_slot : litem;
  assign child_idx  = pick_r ? r_idx[SB-1:0] : l_idx[SB-1:0];
  assign su_stop = !(rd_key > cur_key);

  assign here  = (CB'(s_q) < live) && (rd_slot == SB'(item_q));
  assign lower = key_q < rd_key;

  always_comb begin
    if (!built) begin
      acc_status = (req_command != CMD_LOAD) ? ST_PHASE : ST_OK;
    end else if (req_command == CMD_LOAD) begin
      acc_status = ST_PHASE;
    end else if (req_command == CMD_POP) begin
      acc_status = (live == '0) ? ST_EMPTY : ST_OK;
    end else begin
      acc_status = (32'(req_item) >= 32'(load_idx)) ? ST_RANGE : ST_OK;
    end
  end

  always_comb begin
    stat.err       = err;
    stat.cmd       = cmd_q;
    stat.last_load = li_inc >= {1'b0, eff};
    stat.m_zero    = (m == '0);
    stat.sd_stop   = sd_stop;
    stat.do_sift   = (cmd_q == CMD_DEC) && here && lower;
    stat.at_top    = (a == '0);
    stat.su_stop   = su_stop;
    stat.out_busy  = rsp_valid && !rsp_ready;
  end

  // memory port selection
  always_comb begin
    wr_en  = 1'b0;
    pos_we = 1'b0;
    wa     = a;
    wk     = cur_key;
    ws     = cur_item;
    pa     = cur_item;
    pd     = a;
    ra     = '0;
    unique case (cmd.op)
      OP_LOAD: begin
        wr_en  = 1'b1;
        pos_we = 1'b1;
        wa     = load_idx[SB-1:0];
        wk     = key_q;
        ws     = load_idx[SB-1:0];
        pa     = load_idx[SB-1:0];
        pd     = load_idx[SB-1:0];
      end
      OP_BUILD_RD: ra = m_dec[SB-1:0];
      OP_SD_RDL:   ra = l_idx[SB-1:0];
      OP_SD_RDR:   ra = r_idx[SB-1:0];
      OP_SD_STEP: begin
        wr_en  = 1'b1;
        pos_we = 1'b1;
        if (!sd_stop) begin
          wk = child_key;
          ws = child_item;
          pa = child_item;
        end
      end
      OP_POP_RDL:  ra = live_dec[SB-1:0];
      OP_POS_RD:   ra = SB'(item_q);
      OP_SLOT_RD:  ra = rd_pos;
      OP_SU_RD:    ra = p_idx;
      OP_SU_STEP: begin
        wr_en  = 1'b1;
        pos_we = 1'b1;
        if (!su_stop) begin
          wk = rd_key;
          ws = rd_slot;
          pa = rd_slot;
        end
      end
      OP_PLACE: begin
        wr_en  = 1'b1;
        pos_we = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      key_mem[wa]  <= wk;
      slot_mem[wa] <= ws;
    end
    if (pos_we) begin
      pos_mem[pa] <= pd;
    end
    rd_key  <= key_mem[ra];
    rd_slot <= slot_mem[ra];
    rd_pos  <= pos_mem[ra];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      item_count <= 11'd1;
      built      <= 1'b0;
      live       <= '0;
      load_idx   <= '0;
      m          <= '0;
      err        <= 1'b0;
      rsp_valid  <= 1'b0;
    end else begin
      if (cfg_valid) begin
        item_count <= cfg_item_count;
      end
      if (cmd.op == OP_EMIT) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      unique case (cmd.op)
        OP_ACCEPT:     err <= (acc_status != ST_OK);
        OP_LOAD:       load_idx <= li_inc[CB-1:0];
        OP_BUILD_INIT: begin
          live  <= load_idx;
          m     <= load_idx >> 1;
          built <= 1'b1;
        end
        OP_BUILD_RD:   m <= m_dec;
        OP_POP_RDL:    live <= live_dec;
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_ACCEPT: begin
        cmd_q     <= req_command;
        item_q    <= req_item;
        key_q     <= KEY_BITS'(req_priority);
        status_q  <= acc_status;
        r_item    <= '0;
        r_key     <= '0;
        r_present <= 1'b0;
      end
      OP_BUILD_RD: begin
        a <= m_dec[SB-1:0];
        n <= live;
      end
      OP_CUR_LD: begin
        cur_key  <= rd_key;
        cur_item <= rd_slot;
      end
      OP_SD_RDR: begin
        lkey  <= rd_key;
        litem <= rd_slot;
      end
      OP_SD_STEP: begin
        if (!sd_stop) begin
          a <= child_idx;
        end
      end
      OP_POP_RDL: begin
        r_item <= 10'(rd_slot);
        r_key  <= rd_key;
        a      <= '0;
        n      <= live_dec;
      end
      OP_SLOT_RD: s_q <= rd_pos;
      OP_CHECK: begin
        r_item    <= item_q;
        r_present <= here;
        r_key     <= here ? rd_key : '0;
        if (cmd_q == CMD_DEC) begin
          if (here && lower) begin
            cur_key  <= key_q;
            cur_item <= SB'(item_q);
            a        <= s_q;
            r_key    <= key_q;
          end else begin
            status_q <= ST_NOCHANGE;
          end
        end
      end
      OP_SU_STEP: begin
        if (!su_stop) begin
          a <= p_idx;
        end
      end
      OP_EMIT: begin
        rsp_status          <= status_q;
        rsp_result_item     <= r_item;
        rsp_result_priority <= 32'(r_key);
        rsp_present         <= r_present;
        rsp_min_item        <= (live != '0) ? 10'(rd_slot) : '0;
        rsp_min_priority    <= (live != '0) ? 32'(rd_key) : '0;
        rsp_heap_size       <= 11'(live);
      end
      default: ;
    endcase
  end

  a_live_bound: assert property (@(posedge clk) disable iff (rst)
    32'(live) <= 32'(CAPACITY))
    else $error("heap size beyond capacity");

  a_pop_shrinks: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_POP_RDL) |=> (live == $past(live) - CB'(1)))
    else $error("pop did not shrink the heap by one");

  a_build_size: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_BUILD_INIT) |=> (built && live == $past(load_idx)))
    else $error("build did not take the loaded items");

  a_sift_inside: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_SD_STEP) |-> (CB'(a) < n || n == '0))
    else $error("sift-down hole outside the live heap");

endmodule

// File: sv/indexed_min_heap_decrease_key.sv
// ----------------------------------------------------------------------------
// indexed_min_heap_decrease_key - indexed binary min-heap with decrease-key
// Top level: sequencer plus datapath with the three heap memories.
// ----------------------------------------------------------------------------
// Usage:
//   cfg  : item_count, to be written only while the block is idle (the block does not enforce this); always ready.
//   req  : command/item/priority_req, one request at a time; ready is high
//          only when the previous request has been handed to the output
//          register.
//   rsp  : one response per request, held in an output register until the
//          transfer completes; while the receiver stalls, one further request
//          may be taken and is then held in its final step.
// A pop sifts down from the root (up to 9 levels with the default capacity);
// a decrease sifts up toward the root; errors, queries, non-final loads and
// decreases without change do no sift. The final load also builds the heap
// with a sift-down for each of the first half (rounded down) of the loaded
// slots. Each memory has a single read port, which gives one entry per cycle
// with registered read data.
// Reset puts the block in the loading phase with an empty heap and an
// item_count of 1; memory contents are not cleared.
// ----------------------------------------------------------------------------
module indexed_min_heap_decrease_key
  import imh_pkg::*;
#(
  parameter int CAPACITY = 1024,
  parameter int KEY_BITS = 32
) (
  input  logic clk,
  input  logic rst,
  imh_cfg_if.sink   cfg,
  imh_req_if.sink   req,
  imh_rsp_if.source rsp
);

  imh_cmd_t  cmd;
  imh_stat_t stat;

  assign cfg.ready = 1'b1;

  imh_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  imh_dp #(
    .CAPACITY (CAPACITY),
    .KEY_BITS (KEY_BITS)
  ) u_dp (
    .clk                 (clk),
    .rst                 (rst),
    .cmd                 (cmd),
    .stat                (stat),
    .cfg_valid           (cfg.valid),
    .cfg_item_count      (cfg.item_count),
    .req_command         (req.command),
    .req_item            (req.item),
    .req_priority        (req.priority_req),
    .rsp_valid           (rsp.valid),
    .rsp_ready           (rsp.ready),
    .rsp_status          (rsp.status),
    .rsp_result_item     (rsp.result_item),
    .rsp_result_priority (rsp.result_priority),
    .rsp_present         (rsp.present),
    .rsp_min_item        (rsp.min_item),
    .rsp_min_priority    (rsp.min_priority),
    .rsp_heap_size       (rsp.heap_size)
  );

endmodule
